>>> design/hpt_pkg.sv
// hpt_pkg: shared widths, constants, trim register layouts and helper functions
// for the humidity/pressure/temperature compensation pipeline.
// No dependencies.
package hpt_pkg;

  localparam int RAW_P_W    = 20;
  localparam int RAW_T_W    = 20;
  localparam int RAW_H_W    = 16;
  localparam int TEMP_W     = 32;
  localparam int PRESS_W    = 32;
  localparam int HUM_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;
  localparam int DIV_N_W    = 64;  // dividend / quotient width
  localparam int DIV_D_W    = 31;  // divisor width (arith shift by 33 of 64 bits)

  localparam logic [31:0] OFS_PRESS_T = 32'd128000;
  localparam logic [31:0] PRESS_BASE  = 32'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [31:0] OFS_HUM_T   = 32'd76800;
  localparam logic [31:0] HUM_MAX     = 32'd419430400;
  localparam logic [31:0] HUM_OFS_Y   = 32'd2097152;
  localparam logic [31:0] HUM_RND_X   = 32'd16384;
  localparam logic [31:0] HUM_OFS_A   = 32'd32768;
  localparam logic [31:0] HUM_RND_Y   = 32'd8192;
  localparam logic [HUM_W-1:0] HUM_MAX_OUT = HUM_W'(HUM_MAX >> 12);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_PRESS_C = 3'd3,
    CFG_HUM_A   = 3'd4,
    CFG_HUM_SIX = 3'd5,
    CFG_COMPACT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] t3;
    logic [15:0] t2;
    logic [15:0] t1;
  } temp_trim_t;

  typedef struct packed {
    logic [15:0] p3;
    logic [15:0] p2;
    logic [15:0] p1;
  } press_a_t;

  typedef struct packed {
    logic [15:0] p6;
    logic [15:0] p5;
    logic [15:0] p4;
  } press_b_t;

  typedef struct packed {
    logic [15:0] p9;
    logic [15:0] p8;
    logic [15:0] p7;
  } press_c_t;

  typedef struct packed {
    logic [11:0] h5;
    logic [11:0] h4;
    logic [7:0]  h3;
    logic [15:0] h2;
    logic [7:0]  h1;
  } hum_trim_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

>>> design/humidity_pressure_temp_compensation.sv
// humidity_pressure_temp_compensation: top level of the compensation pipeline.
// Depends on hpt_pkg, hpt_ftemp, hpt_hum, hpt_ppre, hpt_sdiv, hpt_ppost.
//
// Converts one sample of raw readings (20-bit temperature, 20-bit pressure,
// 16-bit humidity) per transfer into temperature in 0.01 degC, pressure in
// Q24.8 Pa and humidity in Q7.10 %RH, or the 16-bit compact forms when
// compact_output is set. The block is a fixed pipeline of 91 stages: 4 for
// the fine temperature, 10 for humidity, 6 for the pressure front end, 66 in
// the 64-bit divider (one quotient bit per stage plus sign handling), 4 for
// the pressure back end and one output register. A new sample can be taken
// every cycle while in_stall is low; results come out in order. The
// whole pipe advances together: a result held on out_valid with out_stall
// high freezes every stage and raises in_stall, nothing is dropped or
// repeated. Trim registers are written through the cfg port (always ready)
// and must only change while no sample is in flight. A zero pressure divisor
// gives pressure 0. There is no memory and no clearing pass after reset.
module humidity_pressure_temp_compensation import hpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RAW_P_W-1:0]    in_raw_pressure,
  input  logic [RAW_T_W-1:0]    in_raw_temperature,
  input  logic [RAW_H_W-1:0]    in_raw_humidity,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TEMP_W-1:0]     out_temperature,
  output logic [PRESS_W-1:0]    out_pressure,
  output logic [HUM_W-1:0]      out_humidity,
  // trim register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // side data carried along with each stage group
  localparam int FT_TAG_W  = RAW_P_W + RAW_H_W;
  localparam int HUM_TAG_W = RAW_P_W + 32;
  localparam int PP_TAG_W  = 32 + HUM_W;
  localparam int DIV_TAG_W = 1 + PP_TAG_W;

  // ---- trim registers ----
  temp_trim_t temp_trim_r;
  press_a_t   press_a_r;
  press_b_t   press_b_r;
  press_c_t   press_c_r;
  hum_trim_t  hum_trim_r;
  logic [7:0] h6_r;
  logic       compact_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r <= '0;
      press_a_r   <= '0;
      press_b_r   <= '0;
      press_c_r   <= '0;
      hum_trim_r  <= '0;
      h6_r        <= '0;
      compact_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP:    temp_trim_r <= cfg_data[47:0];
        CFG_PRESS_A: press_a_r   <= cfg_data[47:0];
        CFG_PRESS_B: press_b_r   <= cfg_data[47:0];
        CFG_PRESS_C: press_c_r   <= cfg_data[47:0];
        CFG_HUM_A:   hum_trim_r  <= cfg_data[55:0];
        CFG_HUM_SIX: h6_r        <= cfg_data[7:0];
        CFG_COMPACT: compact_r   <= cfg_data[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---- global advance: everything moves unless the held result is stalled ----
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---- fine temperature ----
  logic                ft_vld;
  logic [31:0]         ft_tf;
  logic [FT_TAG_W-1:0] ft_tag;

  hpt_ftemp #(.TAG_W(FT_TAG_W)) u_ftemp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .adc_t   (in_raw_temperature),
    .trim    (temp_trim_r),
    .in_tag  ({in_raw_pressure, in_raw_humidity}),
    .out_vld (ft_vld),
    .tf      (ft_tf),
    .out_tag (ft_tag)
  );

  // ---- humidity ----
  logic                 hu_vld;
  logic [HUM_W-1:0]     hu_h;
  logic [HUM_TAG_W-1:0] hu_tag;

  hpt_hum #(.TAG_W(HUM_TAG_W)) u_hum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (ft_vld),
    .tf      (ft_tf),
    .adc_h   (ft_tag[RAW_H_W-1:0]),
    .trim    (hum_trim_r),
    .h6      (h6_r),
    .in_tag  ({ft_tag[FT_TAG_W-1:RAW_H_W], ft_tf}),
    .out_vld (hu_vld),
    .hum     (hu_h),
    .out_tag (hu_tag)
  );

  // ---- pressure front end ----
  logic                pp_vld;
  logic [DIV_N_W-1:0]  pp_num;
  logic [DIV_D_W-1:0]  pp_den;
  logic                pp_zero;
  logic [PP_TAG_W-1:0] pp_tag;

  hpt_ppre #(.TAG_W(PP_TAG_W)) u_ppre (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (hu_vld),
    .tf       (hu_tag[31:0]),
    .adc_p    (hu_tag[HUM_TAG_W-1:32]),
    .trim_a   (press_a_r),
    .trim_b   (press_b_r),
    .in_tag   ({hu_tag[31:0], hu_h}),
    .out_vld  (pp_vld),
    .num      (pp_num),
    .den      (pp_den),
    .den_zero (pp_zero),
    .out_tag  (pp_tag)
  );

  // ---- divider ----
  logic                 dv_vld;
  logic [DIV_N_W-1:0]   dv_quo;
  logic [DIV_TAG_W-1:0] dv_tag;

  hpt_sdiv #(.TAG_W(DIV_TAG_W)) u_sdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pp_vld),
    .num     (pp_num),
    .den     (pp_den),
    .in_tag  ({pp_zero, pp_tag}),
    .out_vld (dv_vld),
    .quo     (dv_quo),
    .out_tag (dv_tag)
  );

  // ---- pressure back end ----
  logic                po_vld;
  logic [PRESS_W-1:0]  po_press;
  logic [PP_TAG_W-1:0] po_tag;

  hpt_ppost #(.TAG_W(PP_TAG_W)) u_ppost (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dv_vld),
    .quo      (dv_quo),
    .den_zero (dv_tag[DIV_TAG_W-1]),
    .trim_c   (press_c_r),
    .in_tag   (dv_tag[PP_TAG_W-1:0]),
    .out_vld  (po_vld),
    .press    (po_press),
    .out_tag  (po_tag)
  );

  // ---- output stage: temperature scaling and result format ----
  logic [31:0]        tf_o, t_w;
  logic [HUM_W-1:0]   h_o;
  logic [TEMP_W-1:0]  temp_r;
  logic [PRESS_W-1:0] press_r;
  logic [HUM_W-1:0]   hum_r;

  assign tf_o = po_tag[PP_TAG_W-1:HUM_W];
  assign h_o  = po_tag[HUM_W-1:0];
  // (tf * 5 + 128) >>> 8
  assign t_w  = asr32((tf_o << 2) + tf_o + 32'd128, 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= po_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (compact_r) begin
        temp_r  <= sx16(t_w[15:0]);
        press_r <= {16'b0, po_press[24:9]};
        hum_r   <= {2'b0, h_o[HUM_W-1:2]};
      end else begin
        temp_r  <= t_w;
        press_r <= po_press;
        hum_r   <= h_o;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = temp_r;
  assign out_pressure    = press_r;
  assign out_humidity    = hum_r;

endmodule

>>> design/hpt_ftemp.sv
// hpt_ftemp: four-stage fine temperature pipeline.
// Depends on hpt_pkg.
module hpt_ftemp import hpt_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [RAW_T_W-1:0] adc_t,
  input  temp_trim_t         trim,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [31:0]        tf,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int DEPTH = 4;

  logic [DEPTH-1:0] vld_r;
  logic [TAG_W-1:0] tag_r [DEPTH];
  logic [31:0]      adc32, t1_32;
  logic [31:0]      a_r, b_r, m1_r, bb_r, v1_r, w_r, tf_r;

  assign adc32 = {{(32-RAW_T_W){1'b0}}, adc_t};
  assign t1_32 = {16'b0, trim.t1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      for (int i = 1; i < DEPTH; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      a_r  <= (adc32 >> 3) - (t1_32 << 1);
      b_r  <= (adc32 >> 4) - t1_32;
      m1_r <= a_r * sx16(trim.t2);
      bb_r <= b_r * b_r;
      v1_r <= asr32(m1_r, 11);
      w_r  <= asr32(bb_r, 12) * sx16(trim.t3);
      tf_r <= v1_r + asr32(w_r, 14);
    end
  end

  assign out_vld = vld_r[DEPTH-1];
  assign tf      = tf_r;
  assign out_tag = tag_r[DEPTH-1];

endmodule

>>> design/hpt_hum.sv
// hpt_hum: ten-stage humidity pipeline, 32-bit wrapping arithmetic, clamp and shift.
// Depends on hpt_pkg.
module hpt_hum import hpt_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        tf,
  input  logic [RAW_H_W-1:0] adc_h,
  input  hum_trim_t          trim,
  input  logic [7:0]         h6,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [HUM_W-1:0]   hum,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int DEPTH = 10;

  logic [DEPTH-1:0] vld_r;
  logic [TAG_W-1:0] tag_r [DEPTH];
  logic [31:0] v_r, xa_r, xa2_r, m5_r, m6_r, m3_r;
  logic [31:0] x_r, a6_r, a3_r, in_r, x4_r, ym_r, x5_r, y_r, x6_r;
  logic [31:0] p_r, ss_r, p8_r, q_r, p9_r;
  logic [31:0] s_w, r_w;
  logic [HUM_W-1:0] hum_r;

  assign s_w = asr32(p_r, 15);
  assign r_w = p9_r - asr32(q_r, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      for (int i = 1; i < DEPTH; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      v_r   <= tf - OFS_HUM_T;
      xa_r  <= ({16'b0, adc_h} << 14) - ({20'b0, trim.h4} << 20) + HUM_RND_X;
      m5_r  <= v_r * {20'b0, trim.h5};
      m6_r  <= v_r * sx8(h6);
      m3_r  <= v_r * {24'b0, trim.h3};
      xa2_r <= xa_r;
      x_r   <= asr32(xa2_r - m5_r, 15);
      a6_r  <= asr32(m6_r, 10);
      a3_r  <= asr32(m3_r, 11) + HUM_OFS_A;
      in_r  <= a6_r * a3_r;
      x4_r  <= x_r;
      ym_r  <= (asr32(in_r, 10) + HUM_OFS_Y) * sx16(trim.h2);
      x5_r  <= x4_r;
      y_r   <= asr32(ym_r + HUM_RND_Y, 14);
      x6_r  <= x5_r;
      p_r   <= x6_r * y_r;
      ss_r  <= s_w * s_w;
      p8_r  <= p_r;
      q_r   <= asr32(ss_r, 7) * {24'b0, trim.h1};
      p9_r  <= p8_r;
      // negative -> 0, above the ceiling -> ceiling, then >> 12
      if (r_w[31]) begin
        hum_r <= '0;
      end else if (r_w > HUM_MAX) begin
        hum_r <= HUM_MAX_OUT;
      end else begin
        hum_r <= r_w[12 +: HUM_W];
      end
    end
  end

  assign out_vld = vld_r[DEPTH-1];
  assign hum     = hum_r;
  assign out_tag = tag_r[DEPTH-1];

endmodule

>>> design/hpt_ppre.sv
// hpt_ppre: six-stage pressure front end; builds the 64-bit dividend and the divisor.
// Depends on hpt_pkg.
module hpt_ppre import hpt_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        tf,
  input  logic [RAW_P_W-1:0] adc_p,
  input  press_a_t           trim_a,
  input  press_b_t           trim_b,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [DIV_N_W-1:0] num,
  output logic [DIV_D_W-1:0] den,
  output logic               den_zero,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int DEPTH = 6;

  logic [DEPTH-1:0] vld_r;
  logic [TAG_W-1:0] tag_r [DEPTH];

  logic signed [23:0] d_r;
  logic [20:0]        pp_r, pp2_r, pp3_r, pp4_r;
  logic signed [47:0] dd_r;
  logic signed [39:0] d5_r, d2_r, d5b_r, d2b_r;
  logic signed [63:0] dd6_r, dd3_r;
  logic [63:0]        v2_r, v1_r, prod_r, num0_r, num_r;
  logic signed [52:0] c_w;
  logic [DIV_D_W-1:0] den_r;
  logic               zero_r;

  assign c_w = $signed(v1_r[52:0] + (53'd1 << 47));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      for (int i = 1; i < DEPTH; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      // the offset result is kept to 24 bits; this is exact while tf fits 22 signed bits
      d_r    <= 24'(tf - OFS_PRESS_T);
      pp_r   <= 21'(PRESS_BASE - {12'b0, adc_p});
      dd_r   <= d_r * d_r;
      d5_r   <= d_r * $signed(trim_b.p5);
      d2_r   <= d_r * $signed(trim_a.p2);
      pp2_r  <= pp_r;
      dd6_r  <= dd_r * $signed(trim_b.p6);
      dd3_r  <= dd_r * $signed(trim_a.p3);
      d5b_r  <= d5_r;
      d2b_r  <= d2_r;
      pp3_r  <= pp2_r;
      v2_r   <= dd6_r + (64'(d5b_r) <<< 17) + (64'($signed(trim_b.p4)) <<< 35);
      v1_r   <= asr64(dd3_r, 8) + (64'(d2b_r) << 12);
      pp4_r  <= pp3_r;
      prod_r <= c_w * $signed({1'b0, trim_a.p1});
      num0_r <= {12'b0, pp4_r, 31'b0} - v2_r;
      den_r  <= prod_r[63:33];
      zero_r <= (prod_r[63:33] == '0);
      num_r  <= num0_r * PRESS_SCALE;
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign num      = num_r;
  assign den      = den_r;
  assign den_zero = zero_r;
  assign out_tag  = tag_r[DEPTH-1];

endmodule

>>> design/hpt_sdiv.sv
// hpt_sdiv: pipelined signed divider, one quotient bit per stage, truncating.
// Depends on hpt_pkg.
module hpt_sdiv import hpt_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [DIV_N_W-1:0] quo,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int N = DIV_N_W;
  localparam int D = DIV_D_W;

  // index 0: magnitudes; index k: after k quotient bits; N+1: signed result
  logic [N+1:0]     vld_r;
  logic [N-1:0]     q_r   [N+1];
  logic [D-1:0]     rem_r [N+1];
  logic [D-1:0]     mb_r  [N+1];
  logic             neg_r [N+1];
  logic [TAG_W-1:0] tag_r [N+1];
  logic [D-1:0]     rem_nxt [N];
  logic             ge_nxt  [N];
  logic [N-1:0]     quo_r;
  logic [TAG_W-1:0] tago_r;

  always_comb begin
    logic [D:0] r2;
    logic [D:0] diff;
    r2   = '0;
    diff = '0;
    for (int k = 0; k < N; k++) begin
      r2         = {rem_r[k], q_r[k][N-1]};
      diff       = r2 - {1'b0, mb_r[k]};
      ge_nxt[k]  = ~diff[D];
      rem_nxt[k] = diff[D] ? r2[D-1:0] : diff[D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]   <= num[N-1] ? (~num + 1'b1) : num;
      mb_r[0]  <= den[D-1] ? (~den + 1'b1) : den;
      rem_r[0] <= '0;
      neg_r[0] <= num[N-1] ^ den[D-1];
      tag_r[0] <= in_tag;
      for (int k = 0; k < N; k++) begin
        q_r[k+1]   <= {q_r[k][N-2:0], ge_nxt[k]};
        rem_r[k+1] <= rem_nxt[k];
        mb_r[k+1]  <= mb_r[k];
        neg_r[k+1] <= neg_r[k];
        tag_r[k+1] <= tag_r[k];
      end
      quo_r  <= neg_r[N] ? (~q_r[N] + 1'b1) : q_r[N];
      tago_r <= tag_r[N];
    end
  end

  assign out_vld = vld_r[N+1];
  assign quo     = quo_r;
  assign out_tag = tago_r;

endmodule

>>> design/hpt_ppost.sv
// hpt_ppost: four-stage pressure back end (second-order terms, offset, zero divisor).
// Depends on hpt_pkg.
module hpt_ppost import hpt_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [DIV_N_W-1:0] quo,
  input  logic               den_zero,
  input  press_c_t           trim_c,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [PRESS_W-1:0] press,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int DEPTH = 4;

  logic [DEPTH-1:0] vld_r;
  logic [TAG_W-1:0] tag_r [DEPTH];
  logic             zero_r [DEPTH-1];
  logic [63:0]      qd_r [DEPTH-1];
  logic [63:0]      s_w, sum_w, sh_w, ll_r, sq_r, v2_r, v2b_r;
  logic [31:0]      cr_r;
  logic signed [63:0] m8_r, m9_r;
  logic [PRESS_W-1:0] press_r;

  assign s_w   = asr64(quo, 13);
  assign sum_w = qd_r[2] + asr64(m9_r, 25) + v2b_r;
  assign sh_w  = asr64(sum_w, 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0]  <= in_tag;
      qd_r[0]   <= quo;
      zero_r[0] <= den_zero;
      for (int i = 1; i < DEPTH; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      for (int i = 1; i < DEPTH-1; i++) begin
        qd_r[i]   <= qd_r[i-1];
        zero_r[i] <= zero_r[i-1];
      end
      // s*s mod 2^64 from 32-bit halves
      ll_r  <= s_w[31:0] * s_w[31:0];
      cr_r  <= s_w[31:0] * s_w[63:32];
      m8_r  <= $signed(quo) * $signed(trim_c.p8);
      sq_r  <= ll_r + {cr_r[30:0], 33'b0};
      v2_r  <= asr64(m8_r, 19);
      m9_r  <= $signed(sq_r) * $signed(trim_c.p9);
      v2b_r <= v2_r;
      if (zero_r[2]) begin
        press_r <= '0;
      end else begin
        press_r <= sh_w[31:0] + (sx16(trim_c.p7) << 4);
      end
    end
  end

  assign out_vld = vld_r[DEPTH-1];
  assign press   = press_r;
  assign out_tag = tag_r[DEPTH-1];

endmodule

>>> design/hpt_checker.sv
// hpt_checker: port-level assertions for the compensation pipeline, bound to the top.
// Depends on hpt_pkg and humidity_pressure_temp_compensation.
module hpt_checker import hpt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [TEMP_W-1:0]  out_temperature,
  input logic [PRESS_W-1:0] out_pressure,
  input logic [HUM_W-1:0]   out_humidity
);

  // input is only held back by a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_temperature)
      && $stable(out_pressure) && $stable(out_humidity)))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // clamp keeps humidity at or below 100 %RH in Q7.10
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity <= HUM_MAX_OUT))
    else $error("humidity above clamp");

endmodule

bind humidity_pressure_temp_compensation hpt_checker u_hpt_checker (.*);

>>> tb/sv/humidity_pressure_temp_compensation_tb.sv
// Testbench for humidity_pressure_temp_compensation: random and directed samples
// under several trim settings and flow-control patterns, checked against an internal predictor.
// Depends on hpt_pkg and the block's RTL.
`timescale 1ns / 1ps

module humidity_pressure_temp_compensation_tb;
  import hpt_pkg::*;

  // One compensated sample as it appears on the result ports.
  typedef struct {
    logic [TEMP_W-1:0]  temp;
    logic [PRESS_W-1:0] press;
    logic [HUM_W-1:0]   hum;
  } reading_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [RAW_P_W-1:0]    in_raw_pressure;
  logic [RAW_T_W-1:0]    in_raw_temperature;
  logic [RAW_H_W-1:0]    in_raw_humidity;
  logic                  out_valid;
  logic                  out_stall;
  logic [TEMP_W-1:0]     out_temperature;
  logic [PRESS_W-1:0]    out_pressure;
  logic [HUM_W-1:0]      out_humidity;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the trim registers.
  logic [47:0] trim_temp, trim_pa, trim_pb, trim_pc;
  logic [55:0] trim_hum;
  logic [7:0]  trim_h6;
  logic        compact_mode;

  reading_t pending_readings[$];
  int       mismatch_cnt;
  int       sender_idle_pct;
  int       receiver_stall_pct;
  int       hold_request;   // cycles of forced out_stall asked for by a test
  int       hold_left;

  humidity_pressure_temp_compensation u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: 32-bit wraps for temperature/humidity, 64-bit wraps for pressure.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] shr_s32(input logic [31:0] x, input int s);
    logic signed [31:0] v;
    v = x;
    return v >>> s;
  endfunction

  function automatic logic [63:0] shr_s64(input logic [63:0] x, input int s);
    logic signed [63:0] v;
    v = x;
    return v >>> s;
  endfunction

  function automatic logic [63:0] ext64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed 64-bit divide, truncating toward zero; min / -1 wraps.
  function automatic logic [63:0] quot_s64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [19:0] adc_p, input logic [19:0] adc_t,
                                          input logic [15:0] adc_h);
    reading_t r;
    logic [31:0] t1, t2, t3, a, b, tf, tv;
    logic [31:0] h1, h2, h3, h4, h5, h6, hv, x, y, inner, s, hres, adc32;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
    // fine temperature
    t1 = {16'd0, trim_temp[15:0]};
    t2 = {{16{trim_temp[31]}}, trim_temp[31:16]};
    t3 = {{16{trim_temp[47]}}, trim_temp[47:32]};
    adc32 = {12'd0, adc_t};
    a  = (adc32 >> 3) - (t1 << 1);
    b  = (adc32 >> 4) - t1;
    tf = shr_s32(a * t2, 11) + shr_s32(shr_s32(b * b, 12) * t3, 14);
    tv = shr_s32(tf * 32'd5 + 32'd128, 8);
    // pressure
    p1 = {48'd0, trim_pa[15:0]};
    p2 = ext64(trim_pa[31:16]);
    p3 = ext64(trim_pa[47:32]);
    p4 = ext64(trim_pb[15:0]);
    p5 = ext64(trim_pb[31:16]);
    p6 = ext64(trim_pb[47:32]);
    p7 = ext64(trim_pc[15:0]);
    p8 = ext64(trim_pc[31:16]);
    p9 = ext64(trim_pc[47:32]);
    v1 = {{32{tf[31]}}, tf} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = shr_s64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = shr_s64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      p = 64'd0;  // zero divisor
    end else begin
      p  = 64'd1048576 - {44'd0, adc_p};
      p  = quot_s64(((p << 31) - v2) * 64'd3125, v1);
      v1 = shr_s64(p9 * shr_s64(p, 13) * shr_s64(p, 13), 25);
      v2 = shr_s64(p8 * p, 19);
      p  = shr_s64(p + v1 + v2, 8) + (p7 << 4);
    end
    // humidity
    h1 = {24'd0, trim_hum[7:0]};
    h2 = {{16{trim_hum[23]}}, trim_hum[23:8]};
    h3 = {24'd0, trim_hum[31:24]};
    h4 = {20'd0, trim_hum[43:32]};
    h5 = {20'd0, trim_hum[55:44]};
    h6 = {{24{trim_h6[7]}}, trim_h6};
    hv = tf - 32'd76800;
    adc32 = {16'd0, adc_h};
    x = shr_s32((adc32 << 14) - (h4 << 20) - h5 * hv + 32'd16384, 15);
    inner = shr_s32(shr_s32(hv * h6, 10) * (shr_s32(hv * h3, 11) + 32'd32768), 10);
    y = shr_s32((inner + 32'd2097152) * h2 + 32'd8192, 14);
    hres = x * y;
    s = shr_s32(hres, 15);
    hres = hres - shr_s32(shr_s32(s * s, 7) * h1, 4);
    if (hres[31]) hres = 32'd0;
    else if (hres > 32'd419430400) hres = 32'd419430400;
    hres = hres >> 12;
    if (compact_mode) begin
      r.temp  = {{16{tv[15]}}, tv[15:0]};
      r.press = {16'd0, p[24:9]};
      r.hum   = {1'b0, hres[17:2]};
    end else begin
      r.temp  = tv;
      r.press = p[31:0];
      r.hum   = hres[16:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random or forced stall, and the checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result transfer: t=%h p=%h h=%h",
                   out_temperature, out_pressure, out_humidity);
      end else begin
        exp_r = pending_readings.pop_front();
        if (out_temperature !== exp_r.temp || out_pressure !== exp_r.press ||
            out_humidity !== exp_r.hum) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp t=%h p=%h h=%h, got t=%h p=%h h=%h",
                     exp_r.temp, exp_r.press, exp_r.hum,
                     out_temperature, out_pressure, out_humidity);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------
  // Offer one sample; valid stays high into the next call unless it idles.
  task automatic send_sample(input logic [19:0] rp, input logic [19:0] rt,
                             input logic [15:0] rh);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_raw_pressure    <= rp;
    in_raw_temperature <= rt;
    in_raw_humidity    <= rh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(compensate(rp, rt, rh));
  endtask

  task automatic send_random_sample();
    logic [19:0] rp, rt;
    // mostly plausible sensor readings, some anywhere in range
    if ($urandom_range(3) == 0) begin
      rp = 20'($urandom);
      rt = 20'($urandom);
    end else begin
      rp = 20'(20'd300000 + $urandom_range(250000));
      rt = 20'(20'd420000 + $urandom_range(200000));
    end
    send_sample(rp, rt, 16'($urandom));
  endtask

  // Let the pipe run dry so trims may change.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_trim(input cfg_idx_t idx, input logic [55:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEMP:    trim_temp    = val[47:0];
      CFG_PRESS_A: trim_pa      = val[47:0];
      CFG_PRESS_B: trim_pb      = val[47:0];
      CFG_PRESS_C: trim_pc      = val[47:0];
      CFG_HUM_A:   trim_hum     = val;
      CFG_HUM_SIX: trim_h6      = val[7:0];
      CFG_COMPACT: compact_mode = val[0];
      default: ;
    endcase
  endtask

  // Typical factory calibration, optionally jittered a little.
  task automatic load_typical_trims(input bit jitter);
    logic [15:0] d;
    d = jitter ? 16'($urandom_range(64)) : 16'd0;
    write_trim(CFG_TEMP,    {8'h0, 16'(-1000) + d, 16'd26435 - d, 16'd27504 + d});
    write_trim(CFG_PRESS_A, {8'h0, 16'd3024 + d, 16'(-10685) - d, 16'd36477 + d});
    write_trim(CFG_PRESS_B, {8'h0, 16'(-7), 16'd140 + d, 16'd2855 - d});
    write_trim(CFG_PRESS_C, {8'h0, 16'd6000 + d, 16'(-14600) + d, 16'd15500 - d});
    write_trim(CFG_HUM_A,   {12'd50 + d[11:0], 12'd313 - d[11:0], 8'd0, 16'd362 + d, 8'd75});
    write_trim(CFG_HUM_SIX, 56'd30 + d);
  endtask

  task automatic load_random_trims();
    write_trim(CFG_TEMP,    56'({$urandom, $urandom}));
    write_trim(CFG_PRESS_A, 56'({$urandom, $urandom}));
    write_trim(CFG_PRESS_B, 56'({$urandom, $urandom}));
    write_trim(CFG_PRESS_C, 56'({$urandom, $urandom}));
    write_trim(CFG_HUM_A,   56'({$urandom, $urandom}));
    write_trim(CFG_HUM_SIX, 56'({$urandom, $urandom}));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset trims are all zero: the pressure divisor is zero.
  task automatic test_zero_trims();
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd415148, 20'd519888, 16'd30000);
    wait_drained();
  endtask

  // Field extremes with typical trims, in both output formats; covers humidity
  // clamped high and low.
  task automatic test_field_extremes();
    load_typical_trims(1'b0);
    for (int c = 0; c < 2; c++) begin
      write_trim(CFG_COMPACT, 56'(c));
      send_sample(20'd0, 20'd0, 16'd0);
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_sample(20'd0, 20'hFFFFF, 16'd0);
      send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
      send_sample(20'd415148, 20'd519888, 16'd30000);
      send_sample(20'd415148, 20'd519888, 16'd65000);
      send_sample(20'd415148, 20'd519888, 16'd100);
      wait_drained();
    end
  endtask

  // Extreme trims: all ones, then sign bits alone (all ones for p1).
  task automatic test_trim_extremes();
    write_trim(CFG_TEMP,    56'hFF_FFFF_FFFF_FFFF);
    write_trim(CFG_PRESS_A, 56'hFF_FFFF_FFFF_FFFF);
    write_trim(CFG_PRESS_B, 56'hFF_FFFF_FFFF_FFFF);
    write_trim(CFG_PRESS_C, 56'hFF_FFFF_FFFF_FFFF);
    write_trim(CFG_HUM_A,   56'hFF_FFFF_FFFF_FFFF);
    write_trim(CFG_HUM_SIX, 56'hFF);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd0, 20'd0, 16'd0);
    wait_drained();
    write_trim(CFG_TEMP,    56'h8000_8000_8000);
    write_trim(CFG_PRESS_A, 56'h8000_8000_FFFF);
    write_trim(CFG_PRESS_B, 56'h8000_8000_8000);
    write_trim(CFG_PRESS_C, 56'h8000_8000_8000);
    write_trim(CFG_HUM_A,   56'h800_800_80_8000_80);
    write_trim(CFG_HUM_SIX, 56'h80);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd0, 20'd0, 16'd0);
    wait_drained();
  endtask

  // Random samples in one flow-control phase, over jittered typical and random trim sets in turn.
  task automatic test_random_phases(input int idle_pct, input int stall_pct, input int n);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      if (k[0]) load_random_trims();
      else load_typical_trims(1'b1);
      write_trim(CFG_COMPACT, 56'($urandom_range(1)));
      repeat (n / 4) send_random_sample();
      wait_drained();
    end
  endtask

  // Receiver holds off long enough that the pipe fills and in_stall rises,
  // then the sender pauses until every result is back.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 400;
    repeat (200) send_random_sample();
    wait_drained();
    repeat (50) send_random_sample();
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_pressure = '0;
    in_raw_temperature = '0;
    in_raw_humidity = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    trim_temp = '0;
    trim_pa = '0;
    trim_pb = '0;
    trim_pc = '0;
    trim_hum = '0;
    trim_h6 = '0;
    compact_mode = 1'b0;
    mismatch_cnt = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_trims();
    test_field_extremes();
    test_trim_extremes();
    test_random_phases(0, 0, 260);
    test_random_phases(63, 0, 260);
    test_random_phases(0, 63, 260);
    test_random_phases(38, 38, 260);
    test_backpressure();

    wait_drained();
    repeat (120) @(posedge clk);
    if (mismatch_cnt == 0 && pending_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
